@@ rtl/hhbm_pkg.sv @@
// Shared types and constants for the HTTP host blocklist matcher.
package hhbm_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [15:0] DEFAULT_PORT   = 16'h0050;
  localparam logic [7:0]  HOST_END       = 8'h0d;
  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [31:0] HOST_TAG       = 32'h486f7374;
  localparam logic [5:0]  MIN_IP_HDR     = 6'd20;
  localparam logic [3:0]  MIN_TCP_WORDS  = 4'd5;

  localparam logic REG_WATCHED_PORT = 1'b0;
  localparam logic REG_SITE_COUNT   = 1'b1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_SKIP    = 2'd1,
    PH_COMPARE = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic       is_load;
    logic       load_ok;
    logic [7:0] data;
    logic [3:0] slot;
    logic [5:0] cpos;
    logic       last;
  } item_t;

endpackage

@@ rtl/hhbm_front.sv @@
// Front end: classifies incoming items and queues them for the back end.
module hhbm_front #(
  parameter int SITES    = 16,
  parameter int SITE_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic [7:0]        data_byte,
  input  logic [3:0]        site_slot,
  input  logic [5:0]        char_pos,
  input  logic              last_byte,
  output logic              q_valid,
  output hhbm_pkg::item_t   q_item,
  input  logic              q_pop
);

  hhbm_pkg::item_t            slots [hhbm_pkg::QDEPTH];
  logic [hhbm_pkg::QAW-1:0]   wr_ptr;
  logic [hhbm_pkg::QAW-1:0]   rd_ptr;
  logic [hhbm_pkg::QAW:0]     count;
  hhbm_pkg::item_t            cls;
  logic                       push;

  always_comb begin
    cls.is_load = (command == hhbm_pkg::CMD_LOAD);
    cls.load_ok = (32'(site_slot) < SITES) && (32'(char_pos) < SITE_LEN);
    cls.data    = data_byte;
    cls.slot    = site_slot;
    cls.cpos    = char_pos;
    cls.last    = last_byte;
  end

  assign in_stall = (count == (hhbm_pkg::QAW+1)'(hhbm_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/hhbm_site_mem.sv @@
// One site name slot: character memory with two registered read ports.
module hhbm_site_mem #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [7:0]               rdata0,
  output logic [7:0]               rdata1
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= (we && waddr == raddr0) ? wdata : mem[raddr0];
    rdata1 <= (we && waddr == raddr1) ? wdata : mem[raddr1];
  end

endmodule

@@ rtl/hhbm_back.sv @@
// Back end: header parsing, Host search, parallel site compare and result register.
module hhbm_back #(
  parameter int SITES      = 16,
  parameter int SITE_LEN   = 64,
  parameter int PACKET_LEN = 2048
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            q_valid,
  input  hhbm_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            detected,
  output logic [3:0]      hit_slot,
  output logic            host_seen,
  output logic            inspected
);

  localparam int POS_W = $clog2(PACKET_LEN);
  localparam int CW    = (POS_W > 8 ? POS_W : 8) + 1;
  localparam int IW    = $clog2(SITE_LEN + 1);
  localparam int AW    = $clog2(SITE_LEN);

  logic [15:0]           watched_port;
  logic [4:0]            site_count;
  logic [POS_W-1:0]      byte_position;
  logic [5:0]            ip_header_bytes;
  logic [7:0]            payload_start;
  logic [2:0]            header_checks;
  hhbm_pkg::phase_t      scan_phase;
  logic                  skip_count;
  logic [31:0]           recent_bytes;
  logic [IW-1:0]         host_char_index;
  logic [SITES-1:0]      still_matching;
  logic [SITES-1:0]      fully_matched;
  logic [SITES-1:0]      out_hits;
  logic                  out_host;
  logic                  out_insp;

  logic [POS_W-1:0]      byte_position_next;
  logic [5:0]            ip_header_bytes_next;
  logic [7:0]            payload_start_next;
  logic [2:0]            header_checks_next;
  hhbm_pkg::phase_t      scan_phase_next;
  logic                  skip_count_next;
  logic [31:0]           recent_bytes_next;
  logic [IW-1:0]         host_char_index_next;
  logic [SITES-1:0]      still_matching_next;
  logic [SITES-1:0]      fully_matched_next;

  logic [7:0]            rd0 [SITES];
  logic [7:0]            rd1 [SITES];
  logic [IW-1:0]         rd_index;
  logic [IW:0]           index_plus;
  logic                  is_packet;
  logic                  cmp1;
  logic                  end1;
  logic                  cmp2;
  logic [7:0]            tcp_start;
  logic [CW-1:0]         pos_x;
  logic [CW-1:0]         ps_x;
  logic [CW-1:0]         tcp_x;
  logic [7:0]            b;
  logic [7:0]            sc0;
  logic [7:0]            sc1;
  logic [7:0]            sc2;
  logic [3:0]            offset;

  assign q_pop     = q_valid && (!out_valid || !out_stall);
  assign is_packet = q_pop && !q_item.is_load;
  assign b         = q_item.data;
  assign index_plus = {1'b0, host_char_index} + 1'b1;

  always_comb begin
    recent_bytes_next    = {recent_bytes[23:0], b};
    ip_header_bytes_next = ip_header_bytes;
    payload_start_next   = payload_start;
    header_checks_next   = header_checks;
    scan_phase_next      = scan_phase;
    skip_count_next      = skip_count;
    host_char_index_next = host_char_index;
    still_matching_next  = still_matching;
    fully_matched_next   = fully_matched;
    cmp1   = 1'b0;
    end1   = 1'b0;
    offset = b[7:4];
    sc0    = '0;
    sc1    = '0;
    sc2    = '0;
    tcp_start = hhbm_pkg::ETH_HDR_LEN + {2'b00, ip_header_bytes};
    pos_x  = CW'(byte_position);
    ps_x   = CW'(payload_start);
    tcp_x  = CW'(tcp_start);

    if (byte_position == POS_W'(13) && recent_bytes_next[15:0] == hhbm_pkg::ETHERTYPE_IPV4)
      header_checks_next[0] = 1'b1;
    if (byte_position == POS_W'(14))
      ip_header_bytes_next = {b[3:0], 2'b00};
    if (byte_position == POS_W'(23) && b == hhbm_pkg::PROTO_TCP &&
        ip_header_bytes >= hhbm_pkg::MIN_IP_HDR)
      header_checks_next[1] = 1'b1;
    if (header_checks_next[1:0] == 2'b11 && pos_x == tcp_x + CW'(3) &&
        recent_bytes_next[15:0] == watched_port)
      header_checks_next[2] = 1'b1;

    if (header_checks_next[2] && pos_x == tcp_x + CW'(12)) begin
      if (offset < hhbm_pkg::MIN_TCP_WORDS)
        header_checks_next[2] = 1'b0;
      else
        payload_start_next = tcp_start + {2'b00, offset, 2'b00};
    end else if (payload_start != '0 && header_checks_next == 3'b111 && pos_x >= ps_x) begin
      case (scan_phase)
        hhbm_pkg::PH_SEARCH: begin
          if (pos_x >= ps_x + CW'(3) && recent_bytes_next == hhbm_pkg::HOST_TAG) begin
            scan_phase_next = hhbm_pkg::PH_SKIP;
            skip_count_next = 1'b0;
          end
        end
        hhbm_pkg::PH_SKIP: begin
          if (skip_count) scan_phase_next = hhbm_pkg::PH_COMPARE;
          else skip_count_next = 1'b1;
        end
        hhbm_pkg::PH_COMPARE: begin
          cmp1 = 1'b1;
          end1 = (b == hhbm_pkg::HOST_END);
          if (end1) scan_phase_next = hhbm_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end

    if (cmp1 && !end1 && 32'(host_char_index) < SITE_LEN)
      host_char_index_next = host_char_index + 1'b1;
    cmp2 = q_item.last && (scan_phase_next == hhbm_pkg::PH_COMPARE);

    for (int s = 0; s < SITES; s++) begin
      sc0 = (32'(host_char_index) < SITE_LEN) ? rd0[s] : 8'd0;
      sc1 = (32'(index_plus) < SITE_LEN) ? rd1[s] : 8'd0;
      if (32'(site_count) > s) begin
        if (cmp1 && still_matching_next[s]) begin
          if (sc0 == 8'd0) begin
            fully_matched_next[s]  = 1'b1;
            still_matching_next[s] = 1'b0;
          end else if (end1 || sc0 != b) begin
            still_matching_next[s] = 1'b0;
          end
        end
        if (cmp2 && still_matching_next[s]) begin
          sc2 = (host_char_index_next != host_char_index) ? sc1 : sc0;
          if (sc2 == 8'd0) fully_matched_next[s] = 1'b1;
          still_matching_next[s] = 1'b0;
        end
      end
    end

    if (byte_position != POS_W'(PACKET_LEN - 1))
      byte_position_next = byte_position + 1'b1;
    else
      byte_position_next = byte_position;
  end

  always_comb begin
    if (is_packet) rd_index = q_item.last ? '0 : host_char_index_next;
    else rd_index = host_char_index;
  end

  for (genvar g = 0; g < SITES; g++) begin : g_site
    logic                  wr_en;
    logic [IW:0]           next_addr;
    assign wr_en = q_pop && q_item.is_load && q_item.load_ok && (32'(q_item.slot) == g);
    assign next_addr = {1'b0, rd_index} + 1'b1;
    hhbm_site_mem #(.DEPTH(SITE_LEN)) u_mem (
      .clk    (clk),
      .we     (wr_en),
      .waddr  (AW'(q_item.cpos)),
      .wdata  (q_item.data),
      .raddr0 (AW'(rd_index)),
      .raddr1 (AW'(next_addr)),
      .rdata0 (rd0[g]),
      .rdata1 (rd1[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      watched_port <= hhbm_pkg::DEFAULT_PORT;
      site_count   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        hhbm_pkg::REG_WATCHED_PORT: watched_port <= cfg_data;
        hhbm_pkg::REG_SITE_COUNT:   site_count   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (is_packet && q_item.last)) begin
      byte_position   <= '0;
      ip_header_bytes <= '0;
      payload_start   <= '0;
      header_checks   <= '0;
      scan_phase      <= hhbm_pkg::PH_SEARCH;
      skip_count      <= 1'b0;
      recent_bytes    <= '0;
      host_char_index <= '0;
      still_matching  <= '1;
      fully_matched   <= '0;
    end else if (is_packet) begin
      byte_position   <= byte_position_next;
      ip_header_bytes <= ip_header_bytes_next;
      payload_start   <= payload_start_next;
      header_checks   <= header_checks_next;
      scan_phase      <= scan_phase_next;
      skip_count      <= skip_count_next;
      recent_bytes    <= recent_bytes_next;
      host_char_index <= host_char_index_next;
      still_matching  <= still_matching_next;
      fully_matched   <= fully_matched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_packet && q_item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_packet && q_item.last) begin
      out_hits <= fully_matched_next;
      out_host <= (scan_phase_next != hhbm_pkg::PH_SEARCH);
      out_insp <= (header_checks_next == 3'b111) && (payload_start_next != '0);
    end
  end

  always_comb begin
    hit_slot = '0;
    for (int s = SITES - 1; s >= 0; s--) begin
      if (out_hits[s]) hit_slot = 4'(s);
    end
  end

  assign detected  = |out_hits;
  assign host_seen = out_host;
  assign inspected = out_insp;

endmodule

@@ rtl/http_host_blocklist_match.sv @@
// Top level of the HTTP host blocklist matcher.
// Takes one item per cycle unless in_stall holds it: either a site table
// character (command 0) or one Ethernet frame byte (command 1). A four-entry
// queue parts the input from the parser, so input and output stall
// independently. Each site slot is its own character memory read one
// position ahead, so every slot compares a host character in the same cycle;
// the sustained rate is one item per clock unless out_stall holds it, and the
// result is registered as the last byte of a frame leaves the queue. The
// table is not cleared by reset; only written entries are meaningful.
module http_host_blocklist_match #(
  parameter int SITES      = 16,
  parameter int SITE_LEN   = 64,
  parameter int PACKET_LEN = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  site_slot,
  input  logic [5:0]  char_pos,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        detected,
  output logic [3:0]  hit_slot,
  output logic        host_seen,
  output logic        inspected
);

  logic            q_valid;
  logic            q_pop;
  hhbm_pkg::item_t q_item;

  hhbm_front #(.SITES(SITES), .SITE_LEN(SITE_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .data_byte (data_byte),
    .site_slot (site_slot),
    .char_pos  (char_pos),
    .last_byte (last_byte),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  hhbm_back #(.SITES(SITES), .SITE_LEN(SITE_LEN), .PACKET_LEN(PACKET_LEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .detected  (detected),
    .hit_slot  (hit_slot),
    .host_seen (host_seen),
    .inspected (inspected)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the HTTP host blocklist matcher.
module testbench;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
    logic [3:0] slot;
    logic [5:0] cpos;
    logic       last;
  } tb_item_t;

  typedef struct {
    logic       detected;
    logic [3:0] hit_slot;
    logic       host_seen;
    logic       inspected;
  } verdict_t;

  localparam int LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = hhbm_pkg::REG_WATCHED_PORT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = hhbm_pkg::CMD_PACKET;
  logic [7:0]  data_byte = '0;
  logic [3:0]  site_slot = '0;
  logic [5:0]  char_pos = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        detected;
  logic [3:0]  hit_slot;
  logic        host_seen;
  logic        inspected;

  http_host_blocklist_match uut (.*);

  always #4 clk = ~clk;

  tb_item_t   pending_q[$];
  verdict_t   verdict_q[$];
  logic [7:0] frm[$];
  logic [7:0] hostq[$];
  logic [7:0] names[16][$];

  int  mismatches = 0;
  int  errors = 0;
  int  cycles = 0;
  int  results_seen = 0;
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  int  hold_left = 0;

  // filter state mirror
  logic [15:0]      m_port;
  logic [4:0]       m_count;
  int               m_pos, m_iphb, m_pstart, m_hidx;
  logic [2:0]       m_checks;
  hhbm_pkg::phase_t m_phase;
  logic [31:0]      m_recent;
  logic [15:0]      m_still, m_full;
  logic [7:0]       m_table[1024];

  function automatic void clear_frame_state();
    m_pos = 0; m_iphb = 0; m_pstart = 0; m_hidx = 0;
    m_checks = '0; m_phase = hhbm_pkg::PH_SEARCH; m_recent = '0;
    m_still = '1; m_full = '0;
  endfunction

  function automatic void match_char(logic [7:0] c, bit at_end);
    int n;
    logic [7:0] sc;
    n = (m_count < 16) ? int'(m_count) : 16;
    for (int s = 0; s < n; s++) begin
      if (m_still[s]) begin
        sc = (m_hidx < 64) ? m_table[s*64 + m_hidx] : 8'd0;
        if (sc == 8'd0) begin
          m_full[s] = 1'b1;
          m_still[s] = 1'b0;
        end else if (at_end || sc != c) begin
          m_still[s] = 1'b0;
        end
      end
    end
    if (!at_end && m_hidx < 64) m_hidx++;
  endfunction

  function automatic void filter_step(tb_item_t it);
    int tcp0, off, hit;
    verdict_t v;
    if (it.cmd == hhbm_pkg::CMD_LOAD) begin
      m_table[it.slot*64 + it.cpos] = it.data;
      return;
    end
    m_recent = {m_recent[23:0], it.data};
    tcp0 = 14 + m_iphb;
    if (m_pos == 13 && m_recent[15:0] == hhbm_pkg::ETHERTYPE_IPV4) m_checks[0] = 1'b1;
    if (m_pos == 14) m_iphb = int'(it.data[3:0]) * 4;
    if (m_pos == 23 && it.data == hhbm_pkg::PROTO_TCP && m_iphb >= 20) m_checks[1] = 1'b1;
    if (m_checks[1:0] == 2'b11 && m_pos == tcp0 + 3 && m_recent[15:0] == m_port)
      m_checks[2] = 1'b1;
    if (m_checks[2] && m_pos == tcp0 + 12) begin
      off = int'(it.data[7:4]);
      if (off < 5) m_checks[2] = 1'b0;
      else m_pstart = tcp0 + off * 4;
    end else if (m_pstart != 0 && m_checks == 3'b111 && m_pos >= m_pstart) begin
      case (m_phase)
        hhbm_pkg::PH_SEARCH: begin
          if (m_pos - m_pstart >= 3 && m_recent == hhbm_pkg::HOST_TAG) begin
            m_phase = hhbm_pkg::PH_SKIP;
            m_hidx = 0;
          end
        end
        hhbm_pkg::PH_SKIP: begin
          m_hidx++;
          if (m_hidx >= 2) begin
            m_phase = hhbm_pkg::PH_COMPARE;
            m_hidx = 0;
          end
        end
        hhbm_pkg::PH_COMPARE: begin
          if (it.data == hhbm_pkg::HOST_END) begin
            match_char(8'd0, 1'b1);
            m_phase = hhbm_pkg::PH_DONE;
          end else begin
            match_char(it.data, 1'b0);
          end
        end
        default: ;
      endcase
    end
    if (m_pos < 2047) m_pos++;
    if (!it.last) return;
    if (m_phase == hhbm_pkg::PH_COMPARE) match_char(8'd0, 1'b1);
    hit = 0;
    for (int s = 15; s >= 0; s--) if (m_full[s]) hit = s;
    v.detected  = (m_full != 0);
    v.hit_slot  = hit[3:0];
    v.host_seen = (m_phase != hhbm_pkg::PH_SEARCH);
    v.inspected = (m_checks == 3'b111 && m_pstart != 0);
    verdict_q.push_back(v);
    clear_frame_state();
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        filter_step('{command, data_byte, site_slot, char_pos, last_byte});
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
        tb_item_t it;
        it = pending_q.pop_front();
        in_valid  <= 1'b1;
        command   <= it.cmd;
        data_byte <= it.data;
        site_slot <= it.slot;
        char_pos  <= it.cpos;
        last_byte <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          errors++;
          if (mismatches < 10) $display("unexpected result at cycle %0d", cycles);
          mismatches++;
        end else begin
          verdict_t e;
          e = verdict_q.pop_front();
          if (e.detected !== detected || e.hit_slot !== hit_slot ||
              e.host_seen !== host_seen || e.inspected !== inspected) begin
            errors++;
            if (mismatches < 10)
              $display("mismatch: expected det=%0b slot=%0d host=%0b insp=%0b, got %0b %0d %0b %0b",
                       e.detected, e.hit_slot, e.host_seen, e.inspected,
                       detected, hit_slot, host_seen, inspected);
            mismatches++;
          end
        end
      end
      if (hold_go && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 26);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_item(logic cmd, logic [7:0] d, logic [3:0] s, logic [5:0] p, logic l);
    tb_item_t it;
    it = '{cmd, d, s, p, l};
    pending_q.push_back(it);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == hhbm_pkg::REG_WATCHED_PORT) m_port = val;
    else m_count = val[4:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || verdict_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // new name for a slot; len 64 fills the slot with no terminator
  task automatic load_site(int s, int len);
    logic [7:0] c;
    names[s] = {};
    for (int i = 0; i < len; i++) begin
      c = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(97, 122));
      names[s].push_back(c);
      push_item(hhbm_pkg::CMD_LOAD, c, s[3:0], i[5:0], $urandom_range(0, 1));
    end
    if (len < 64)
      push_item(hhbm_pkg::CMD_LOAD, 8'd0, s[3:0], len[5:0], $urandom_range(0, 1));
  endtask

  task automatic push_frame();
    for (int i = 0; i < frm.size(); i++)
      push_item(hhbm_pkg::CMD_PACKET, frm[i], 4'($urandom), 6'($urandom),
                i == frm.size() - 1);
  endtask

  task automatic add_rand(int n);
    repeat (n) frm.push_back(8'($urandom));
  endtask

  task automatic build_headers(bit eth_ok, int ihl, bit tcp, logic [15:0] dport, int doff);
    frm = {};
    add_rand(12);
    frm.push_back(eth_ok ? 8'h08 : 8'($urandom_range(0, 255)));
    frm.push_back(eth_ok ? 8'h00 : 8'h06);
    frm.push_back({4'h4, 4'(ihl)});
    add_rand(8);
    frm.push_back(tcp ? hhbm_pkg::PROTO_TCP : 8'd17);
    add_rand(10);
    if (ihl > 5) add_rand((ihl - 5) * 4);
    add_rand(2);
    frm.push_back(dport[15:8]);
    frm.push_back(dport[7:0]);
    add_rand(8);
    frm.push_back({4'(doff), 4'($urandom)});
    add_rand(7);
    if (doff > 5) add_rand((doff - 5) * 4);
  endtask

  // host name: a listed site, a site with extra tail, a cut site, or noise
  task automatic pick_host();
    int s, k;
    s = $urandom_range(0, 15);
    hostq = names[s];
    k = $urandom_range(0, 3);
    if (k == 1) repeat ($urandom_range(1, 5)) hostq.push_back(8'($urandom_range(97, 122)));
    else if (k == 2 && hostq.size() > 0) hostq.pop_back();
    else if (k == 3) begin
      hostq = {};
      repeat ($urandom_range(0, 12)) hostq.push_back(8'($urandom_range(97, 122)));
    end
  endtask

  task automatic add_host(bit cr);
    frm.push_back("H"); frm.push_back("o"); frm.push_back("s"); frm.push_back("t");
    frm.push_back(":"); frm.push_back(" ");
    foreach (hostq[i]) frm.push_back(hostq[i]);
    if (cr) begin
      frm.push_back(hhbm_pkg::HOST_END);
      frm.push_back(8'h0a);
    end
  endtask

  task automatic good_frame();
    build_headers(1, $urandom_range(0, 3) == 0 ? 6 : 5, 1, m_port,
                  $urandom_range(0, 3) == 0 ? $urandom_range(6, 15) : 5);
    add_rand($urandom_range(0, 12));
    pick_host();
    add_host($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 5) == 0) begin
      pick_host();
      add_host(1);
    end
    add_rand($urandom_range(0, 10));
  endtask

  task automatic random_frame();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      good_frame();
    end else if (k == 7) begin
      frm = {};
      add_rand($urandom_range(1, 60));
    end else begin
      build_headers($urandom_range(0, 3) != 0, $urandom_range(0, 15), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) == 0 ? 16'($urandom) : m_port, $urandom_range(0, 15));
      pick_host();
      add_host(1);
      if ($urandom_range(0, 1) == 0) void'(frm.pop_back());
    end
    push_frame();
  endtask

  initial begin
    logic [15:0] ports[6];
    logic [4:0]  counts[6];
    ports  = '{16'd80, 16'd0, 16'hffff, 16'($urandom), 16'd443, 16'd8080};
    counts = '{5'd16, 5'd31, 5'd5, 5'd0, 5'd1, 5'd17};
    m_port = hhbm_pkg::DEFAULT_PORT;
    m_count = '0;
    clear_frame_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // every slot gets a name before any compare; all but slot 7 (64 chars) also get a terminator
    for (int s = 0; s < 16; s++)
      load_site(s, s == 3 ? 0 : (s == 7 ? 64 : $urandom_range(1, 12)));
    drain();

    // directed frames with all sites valid
    write_reg(hhbm_pkg::REG_SITE_COUNT, 5'd16);
    hostq = names[5];
    build_headers(1, 5, 1, m_port, 5); add_host(1); push_frame();
    build_headers(0, 5, 1, m_port, 5); add_host(1); push_frame();
    build_headers(1, 4, 1, m_port, 5); add_host(1); push_frame();
    build_headers(1, 6, 1, m_port, 5); add_host(1); push_frame();
    build_headers(1, 5, 0, m_port, 5); add_host(1); push_frame();
    build_headers(1, 5, 1, m_port ^ 16'h0100, 5); add_host(1); push_frame();
    build_headers(1, 5, 1, m_port, 4); add_host(1); push_frame();
    build_headers(1, 5, 1, m_port, 15); add_host(0); push_frame();
    build_headers(1, 5, 1, m_port, 5); add_rand(5); push_frame();
    hostq = names[7];
    repeat (8) hostq.push_back("z");
    build_headers(1, 5, 1, m_port, 5); add_host(1); push_frame();
    hostq = names[9];
    build_headers(1, 5, 1, m_port, 5); add_host(1);
    hostq = names[2]; add_host(1); push_frame();
    frm = {8'hff}; push_frame();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(hhbm_pkg::REG_WATCHED_PORT, ports[ph]);
      write_reg(hhbm_pkg::REG_SITE_COUNT, counts[ph]);
      calm <= (ph == 1);
      for (int f = 0; f < 1 + (ph % 2); f++) begin
        if ($urandom_range(0, 3) == 0) load_site($urandom_range(0, 15), $urandom_range(0, 14));
        random_frame();
      end
      if (ph == 4) begin
        while (pending_q.size() > 0) @(posedge clk);
        hold_go <= 1'b1;
        repeat (40)
          push_item(hhbm_pkg::CMD_PACKET, 8'($urandom), 4'($urandom), 6'($urandom), 1'b1);
      end
      drain();
    end

    if (verdict_q.size() > 0) errors += verdict_q.size();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
